FILE: src/owtm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and tables of the one-wire temperature master.
// No dependencies; imported by every module of the block.
package owtm_pkg;

  // Commands carried by an input transfer
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_RESET = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_TEMP  = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_WAIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WR1_LOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RD_LOW      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP         = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CONV_WAIT   = 3'd7;

  // Register values after reset
  localparam logic [9:0]  RST_RESET_LOW  = 10'd480;
  localparam logic [7:0]  RST_PRES_WAIT  = 8'd80;
  localparam logic [9:0]  RST_RESET_TAIL = 10'd400;
  localparam logic [7:0]  RST_SLOT       = 8'd60;
  localparam logic [3:0]  RST_WR1_LOW    = 4'd1;
  localparam logic [3:0]  RST_RD_LOW     = 4'd2;
  localparam logic [15:0] RST_GAP        = 16'd1000;
  localparam logic [19:0] RST_CONV_WAIT  = 20'd800000;

  // Bus commands of the temperature sequence
  localparam logic [7:0] ROM_SKIP   = 8'hCC;
  localparam logic [7:0] FN_CONVERT = 8'h44;
  localparam logic [7:0] FN_RD_PAD  = 8'hBE;

  // Kinds of item within an operation
  localparam logic [2:0] IT_END   = 3'd0;
  localparam logic [2:0] IT_RESET = 3'd1;
  localparam logic [2:0] IT_WRITE = 3'd2;
  localparam logic [2:0] IT_READ  = 3'd3;
  localparam logic [2:0] IT_GAP   = 3'd4;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] write_byte;
    logic       line_level;
  } in_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic               presence;
    logic [7:0]         read_value;
    logic signed [15:0] temperature;
  } out_t;

  typedef struct packed {
    logic [9:0]  reset_low_us;
    logic [7:0]  presence_wait_us;
    logic [9:0]  reset_tail_us;
    logic [7:0]  slot_us;
    logic [3:0]  write_one_low_us;
    logic [3:0]  read_low_us;
    logic [15:0] post_reset_gap_us;
    logic [19:0] convert_wait_us;
  } cfg_t;

  // Item kind at a position of an operation
  function automatic logic [2:0] item_kind(input logic [2:0] op, input logic [3:0] pos);
    logic [2:0] k;
    k = IT_END;
    if (op == CMD_TEMP) begin
      case (pos)
        4'd0, 4'd5:               k = IT_RESET;
        4'd1, 4'd4:               k = IT_GAP;
        4'd2, 4'd3, 4'd6, 4'd7:   k = IT_WRITE;
        4'd8, 4'd9:               k = IT_READ;
        default:                  k = IT_END;
      endcase
    end else if (pos == 4'd0) begin
      case (op)
        CMD_RESET: k = IT_RESET;
        CMD_WRITE: k = IT_WRITE;
        CMD_READ:  k = IT_READ;
        default:   k = IT_END;
      endcase
    end
    return k;
  endfunction

  // Byte sent at a write position of the temperature sequence
  function automatic logic [7:0] temp_byte(input logic [3:0] pos);
    logic [7:0] b;
    case (pos)
      4'd2, 4'd6: b = ROM_SKIP;
      4'd3:       b = FN_CONVERT;
      4'd7:       b = FN_RD_PAD;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: src/owtm_cfg.sv
`timescale 1ns / 1ps
// Timing register file of the one-wire master: write-only, reset to bus defaults.
// Depends on owtm_pkg.
module owtm_cfg
  import owtm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_us      <= RST_RESET_LOW;
      cfg_r.presence_wait_us  <= RST_PRES_WAIT;
      cfg_r.reset_tail_us     <= RST_RESET_TAIL;
      cfg_r.slot_us           <= RST_SLOT;
      cfg_r.write_one_low_us  <= RST_WR1_LOW;
      cfg_r.read_low_us       <= RST_RD_LOW;
      cfg_r.post_reset_gap_us <= RST_GAP;
      cfg_r.convert_wait_us   <= RST_CONV_WAIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RESET_LOW:  cfg_r.reset_low_us      <= cfg_wdata[9:0];
        CFG_PRES_WAIT:  cfg_r.presence_wait_us  <= cfg_wdata[7:0];
        CFG_RESET_TAIL: cfg_r.reset_tail_us     <= cfg_wdata[9:0];
        CFG_SLOT:       cfg_r.slot_us           <= cfg_wdata[7:0];
        CFG_WR1_LOW:    cfg_r.write_one_low_us  <= cfg_wdata[3:0];
        CFG_RD_LOW:     cfg_r.read_low_us       <= cfg_wdata[3:0];
        CFG_GAP:        cfg_r.post_reset_gap_us <= cfg_wdata[15:0];
        CFG_CONV_WAIT:  cfg_r.convert_wait_us   <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: src/one_wire_temperature_master.sv
`timescale 1ns / 1ps
// One-wire bus master with reset/presence, byte write, byte read and temperature sequence.
// Depends on owtm_pkg and owtm_cfg.
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   in      | in_valid, in_ready, in_data (in_t) | tick in
//   out     | out_valid, out_ready, out_data     | status out
//   cfg     | cfg_we, cfg_index, cfg_wdata       | register write
//
// Each input transfer is one bus tick; its status appears on out the next cycle.
// One tick per cycle: the bus state machine updates in a single pass into the
// output register. in_ready drops only while a status waits and out_ready is low.
// Synchronous active-low reset clears the sequencer and restores timing defaults.
module one_wire_temperature_master
  import owtm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_RST_LOW  = 4'd1;
  localparam logic [3:0] PH_RST_WAIT = 4'd2;
  localparam logic [3:0] PH_RST_TAIL = 4'd3;
  localparam logic [3:0] PH_W_LOW    = 4'd4;
  localparam logic [3:0] PH_W_HIGH   = 4'd5;
  localparam logic [3:0] PH_W_REC    = 4'd6;
  localparam logic [3:0] PH_R_LOW    = 4'd7;
  localparam logic [3:0] PH_R_REST   = 4'd8;
  localparam logic [3:0] PH_GAP      = 4'd9;

  cfg_t cfg;

  owtm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  logic [3:0]  step_r,   step_nxt;
  logic [19:0] tick_r,   tick_nxt;
  logic [2:0]  bit_r,    bit_nxt;
  logic [7:0]  shift_r,  shift_nxt;
  logic [7:0]  low_r,    low_nxt;
  logic [7:0]  last_r,   last_nxt;
  logic [15:0] temp_r,   temp_nxt;
  logic        pres_r,   pres_nxt;
  logic [2:0]  op_r,     op_nxt;
  logic [3:0]  pos_r,    pos_nxt;
  logic        drive_nxt, done_nxt;

  logic  out_valid_r;
  out_t  out_data_r;
  logic  in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin : seq
    logic [19:0] len_raw;
    logic [19:0] len;
    logic [20:0] tick_inc;
    logic        end_it;
    logic [2:0]  kind;

    step_nxt  = step_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    low_nxt   = low_r;
    last_nxt  = last_r;
    temp_nxt  = temp_r;
    pres_nxt  = pres_r;
    op_nxt    = op_r;
    pos_nxt   = pos_r;
    drive_nxt = 1'b0;
    done_nxt  = 1'b0;
    len_raw   = 20'd1;
    len       = 20'd1;
    tick_inc  = 21'd0;
    end_it    = 1'b0;
    kind      = IT_END;

    // start a new operation on an idle tick
    if (step_nxt == PH_IDLE && in_data.command inside {[CMD_RESET:CMD_TEMP]}) begin
      op_nxt   = in_data.command;
      pos_nxt  = 4'd0;
      tick_nxt = 20'd0;
      bit_nxt  = 3'd0;
      case (in_data.command)
        CMD_WRITE: begin
          shift_nxt = in_data.write_byte;
          step_nxt  = PH_W_LOW;
        end
        CMD_READ: begin
          shift_nxt = 8'd0;
          step_nxt  = PH_R_LOW;
        end
        default: step_nxt = PH_RST_LOW;
      endcase
    end

    if (step_nxt != PH_IDLE) begin
      case (step_nxt)
        PH_RST_LOW:  len_raw = {10'd0, cfg.reset_low_us};
        PH_RST_WAIT: len_raw = {12'd0, cfg.presence_wait_us};
        PH_RST_TAIL: len_raw = {10'd0, cfg.reset_tail_us};
        PH_W_LOW:    len_raw = shift_nxt[bit_nxt] ? {16'd0, cfg.write_one_low_us}
                                                  : {12'd0, cfg.slot_us};
        PH_W_HIGH:   len_raw = {12'd0, cfg.slot_us};
        PH_R_LOW:    len_raw = {16'd0, cfg.read_low_us};
        PH_R_REST:   len_raw = {12'd0, cfg.slot_us};
        PH_GAP:      len_raw = (pos_nxt == 4'd1) ? {4'd0, cfg.post_reset_gap_us}
                                                 : cfg.convert_wait_us;
        default:     len_raw = 20'd1;
      endcase
      len = (len_raw == 20'd0) ? 20'd1 : len_raw;

      drive_nxt = (step_nxt == PH_RST_LOW) || (step_nxt == PH_W_LOW) ||
                  (step_nxt == PH_R_LOW);
      tick_inc  = {1'b0, tick_nxt} + 21'd1;

      // presence is the inverted line level (a low line means present) on the last tick of the wait
      if (step_nxt == PH_RST_WAIT && tick_inc >= {1'b0, len})
        pres_nxt = !in_data.line_level;
      if (step_nxt == PH_R_REST && tick_nxt == 20'd0 && in_data.line_level)
        shift_nxt[bit_nxt] = 1'b1;

      tick_nxt = tick_inc[19:0];
      if (tick_inc >= {1'b0, len}) begin
        tick_nxt = 20'd0;
        case (step_nxt)
          PH_RST_LOW:  step_nxt = PH_RST_WAIT;
          PH_RST_WAIT: step_nxt = PH_RST_TAIL;
          PH_W_LOW:    step_nxt = shift_nxt[bit_nxt] ? PH_W_HIGH : PH_W_REC;
          PH_W_HIGH, PH_W_REC: begin
            if (bit_nxt == 3'd7) end_it = 1'b1;
            else begin
              bit_nxt  = bit_nxt + 3'd1;
              step_nxt = PH_W_LOW;
            end
          end
          PH_R_LOW:    step_nxt = PH_R_REST;
          PH_R_REST: begin
            if (bit_nxt == 3'd7) begin
              last_nxt = shift_nxt;
              if (op_nxt == CMD_TEMP && pos_nxt == 4'd8) low_nxt = shift_nxt;
              if (op_nxt == CMD_TEMP && pos_nxt == 4'd9) temp_nxt = {shift_nxt, low_nxt};
              end_it = 1'b1;
            end else begin
              bit_nxt  = bit_nxt + 3'd1;
              step_nxt = PH_R_LOW;
            end
          end
          default: end_it = 1'b1;
        endcase
      end
    end

    // move on to the next item of the operation, or finish
    if (end_it) begin
      pos_nxt  = pos_nxt + 4'd1;
      kind     = item_kind(op_nxt, pos_nxt);
      tick_nxt = 20'd0;
      bit_nxt  = 3'd0;
      case (kind)
        IT_RESET: step_nxt = PH_RST_LOW;
        IT_WRITE: begin
          if (op_nxt == CMD_TEMP) shift_nxt = temp_byte(pos_nxt);
          step_nxt = PH_W_LOW;
        end
        IT_READ: begin
          shift_nxt = 8'd0;
          step_nxt  = PH_R_LOW;
        end
        IT_GAP:   step_nxt = PH_GAP;
        default: begin
          step_nxt = PH_IDLE;
          op_nxt   = CMD_NONE;
          pos_nxt  = 4'd0;
          done_nxt = 1'b1;
        end
      endcase
    end
  end

  // advance the bus state only on an input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= PH_IDLE;
      tick_r  <= 20'd0;
      bit_r   <= 3'd0;
      shift_r <= 8'd0;
      low_r   <= 8'd0;
      last_r  <= 8'd0;
      temp_r  <= 16'd0;
      pres_r  <= 1'b0;
      op_r    <= CMD_NONE;
      pos_r   <= 4'd0;
    end else if (in_fire) begin
      step_r  <= step_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      low_r   <= low_nxt;
      last_r  <= last_nxt;
      temp_r  <= temp_nxt;
      pres_r  <= pres_nxt;
      op_r    <= op_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.drive_low   <= drive_nxt;
      out_data_r.busy_res    <= (step_nxt != PH_IDLE);
      out_data_r.done_res    <= done_nxt;
      out_data_r.presence    <= pres_nxt;
      out_data_r.read_value  <= last_nxt;
      out_data_r.temperature <= temp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> !out_data_r.busy_res)
    else $error("done reported while still busy");

  a_drive_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.drive_low |-> out_data_r.busy_res)
    else $error("bus driven low outside an operation");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == PH_IDLE |-> (tick_r == 20'd0 && op_r == CMD_NONE && pos_r == 4'd0))
    else $error("idle with leftover operation state");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(step_r) && $stable(tick_r) && $stable(bit_r))
    else $error("bus state moved without a transfer");

endmodule
